### hw/rtl/fskmod_pkg.sv
// Shared constants, codes and framing helpers for the FSK UART tone modulator.
// No dependencies; imported by fsk_uart_tone_modulator and its testbench.
package fskmod_pkg;

   localparam int SAMPLE_WIDTH_DEFAULT   = 8;
   localparam int SAMPLES_PER_BIT_PERIOD = 32;
   localparam int PHASE_FRAC_BITS        = 8;
   localparam int MAX_FRAME_LENGTH       = 12;
   localparam int CSR_ADDR_WIDTH         = 5;

   typedef logic [1:0] req_kind_type;
   localparam req_kind_type REQ_ADVANCE = 2'd0;
   localparam req_kind_type REQ_BYTE    = 2'd1;
   localparam req_kind_type REQ_CARRIER = 2'd2;

   typedef logic [1:0] parity_mode_type;
   localparam parity_mode_type PAR_SPACE = 2'd0;
   localparam parity_mode_type PAR_MARK  = 2'd1;
   localparam parity_mode_type PAR_EVEN  = 2'd2;
   localparam parity_mode_type PAR_ODD   = 2'd3;

   typedef logic [2:0] reg_index_type;
   localparam reg_index_type REG_DATA_BITS      = 3'd0;
   localparam reg_index_type REG_PARITY_ENABLE  = 3'd1;
   localparam reg_index_type REG_PARITY_MODE    = 3'd2;
   localparam reg_index_type REG_STOP_BITS      = 3'd3;
   localparam reg_index_type REG_STEP_CH0_SPACE = 3'd4;
   localparam reg_index_type REG_STEP_CH0_MARK  = 3'd5;
   localparam reg_index_type REG_STEP_CH1_SPACE = 3'd6;
   localparam reg_index_type REG_STEP_CH1_MARK  = 3'd7;

   // First quadrant of a sine of amplitude 127, sampled at the bin centres.
   localparam logic [6:0] SINE_QUADRANT [64] = '{
      7'd2,   7'd5,   7'd8,   7'd11,  7'd14,  7'd17,  7'd20,  7'd23,
      7'd26,  7'd29,  7'd32,  7'd35,  7'd38,  7'd41,  7'd44,  7'd47,
      7'd50,  7'd53,  7'd56,  7'd58,  7'd61,  7'd64,  7'd67,  7'd69,
      7'd72,  7'd74,  7'd77,  7'd79,  7'd82,  7'd84,  7'd86,  7'd89,
      7'd91,  7'd93,  7'd95,  7'd97,  7'd99,  7'd101, 7'd103, 7'd105,
      7'd106, 7'd108, 7'd110, 7'd111, 7'd113, 7'd114, 7'd115, 7'd117,
      7'd118, 7'd119, 7'd120, 7'd121, 7'd122, 7'd123, 7'd124, 7'd124,
      7'd125, 7'd125, 7'd126, 7'd126, 7'd127, 7'd127, 7'd127, 7'd127
   };

   // Data bit count held in the legal range of five to eight.
   function automatic logic [3:0] clamp_data_bits(input logic [3:0] raw);
      if (raw < 4'd5) begin
         return 4'd5;
      end else if (raw > 4'd8) begin
         return 4'd8;
      end
      return raw;
   endfunction

   // Stop bit count held in the legal range of one to two.
   function automatic logic [1:0] clamp_stop_bits(input logic [1:0] raw);
      if (raw == 2'd0) begin
         return 2'd1;
      end else if (raw == 2'd3) begin
         return 2'd2;
      end
      return raw;
   endfunction

   function automatic logic [3:0] frame_length(input logic [3:0] nd, input logic pe,
                                                input logic [1:0] ns);
      return 4'd1 + nd + {3'b000, pe} + {2'b00, ns};
   endfunction

   // Start bit in bit 0, then data LSB first, optional parity, stop bits.
   function automatic logic [15:0] frame_word(input logic [7:0] data, input logic [3:0] nd,
                                              input logic pe, input parity_mode_type mode,
                                              input logic [1:0] ns);
      logic        par;
      logic [2:0]  upper;
      logic [7:0]  keep;
      logic [15:0] w;
      unique case (mode)
         PAR_SPACE: par = 1'b0;
         PAR_MARK:  par = 1'b1;
         PAR_EVEN:  par = ^data;
         PAR_ODD:   par = ~^data;
      endcase
      upper = pe ? {ns[1], 1'b1, par} : {1'b0, ns[1], 1'b1};
      keep  = data & 8'((9'h001 << nd) - 9'h001);
      w     = ({13'b0, upper} << nd) | {8'b0, keep};
      return {w[14:0], 1'b0};
   endfunction

endpackage

### hw/rtl/fsk_uart_tone_modulator.sv
// FSK tone modulator with UART framing: framing, bit timing, phase accumulator,
// sine quadrant ROM and a two-stage elastic result path. Depends on fskmod_pkg.
//
//  Port group   Direction  Handshake         Content
//  req_*        in         tvalid/tready     tdata: data_byte; tuser: req_type, channel
//  rsp_*        out        tvalid/tready     tdata: sample; tuser: status
//  csr_*        in/out     APB, pready = 1   eight framing and tone step registers
//
// One request is taken in every cycle unless both stages are full. Its sample passes two
// registers: the first is the synchronous read port of the sine ROM, the second the output
// stage. All line state updates in the cycle a request is accepted, so requests may follow
// back to back. A stalled output holds its sample while one more request is taken into the
// ROM stage; only with both stages full does req_tready fall. Reset is synchronous and
// returns all line state, both stages' valid flags and the registers to their reset values.
module fsk_uart_tone_modulator #(
   parameter int SAMPLE_WIDTH = fskmod_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   // Request channel
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   input  logic [7:0]                                req_tdata,   // [7:0] data_byte
   input  logic [2:0]                                req_tuser,   // [1:0] req_type, [2] channel
   // Result channel
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   output logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] rsp_tdata,   // sample, zero padded
   output logic                                      rsp_tuser,   // [0] status
   // Register port
   input  logic                                      csr_psel,
   input  logic                                      csr_penable,
   input  logic                                      csr_pwrite,
   input  logic [fskmod_pkg::CSR_ADDR_WIDTH-1:0]     csr_paddr,
   input  logic [31:0]                               csr_pwdata,
   output logic [31:0]                               csr_prdata,
   output logic                                      csr_pready
);

   import fskmod_pkg::*;

   localparam int RspDataWidth = ((SAMPLE_WIDTH + 7) / 8) * 8;

   // Configuration registers
   logic [3:0]      data_bits_ff;
   logic            parity_enable_ff;
   parity_mode_type parity_mode_ff;
   logic [1:0]      stop_bits_ff;
   // Tone steps indexed by {channel, bit value}.
   logic [15:0]     tone_step_ff [4];

   // Line state
   logic [15:0] phase_acc_ff,      phase_acc_in;
   logic [15:0] bit_step_ff,       bit_step_in;
   logic        active_channel_ff, active_channel_in;
   logic [5:0]  samples_left_ff,   samples_left_in;
   logic [15:0] shift_word_ff,     shift_word_in;
   logic [15:0] held_word_ff,      held_word_in;
   logic        held_full_ff,      held_full_in;
   logic [3:0]  bits_left_ff,      bits_left_in;

   // Result path: ROM stage, then output stage.
   logic                    pipe_valid_ff, pipe_valid_in;
   logic [6:0]              pipe_mag_ff;
   logic                    pipe_neg_ff;
   logic                    pipe_status_ff;
   logic                    rsp_valid_ff,  rsp_valid_in;
   logic [SAMPLE_WIDTH-1:0] rsp_sample_ff;
   logic                    rsp_status_ff;

   logic                    pipe_move;
   logic                    req_fire;
   logic                    csr_write;
   reg_index_type           csr_index;

   req_kind_type            req_kind;
   logic                    req_channel;
   logic                    pushing;
   logic                    busy_now;
   logic                    refuse;
   logic                    accept_push;
   logic                    load;
   logic                    held_write;
   logic                    busy;
   logic                    boundary;
   logic                    take_bit;
   logic [3:0]              nd;
   logic [1:0]              ns;
   logic [15:0]             new_word;
   logic [15:0]             shift_cur;
   logic [3:0]              bits_cur;
   logic                    channel_sel;
   logic                    bit_sel;
   logic                    status;
   logic [7:0]              phase_top;
   logic [5:0]              rom_index;
   logic [SAMPLE_WIDTH-1:0] mag_ext;

   // ---------------------------------------------------------------- register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         data_bits_ff     <= 4'd8;
         parity_enable_ff <= 1'b0;
         parity_mode_ff   <= PAR_SPACE;
         stop_bits_ff     <= 2'd1;
         for (int i = 0; i < 4; i++) begin
            tone_step_ff[i] <= 16'd0;
         end
      end else if (csr_write) begin
         unique case (csr_index)
            REG_DATA_BITS:      data_bits_ff     <= csr_pwdata[3:0];
            REG_PARITY_ENABLE:  parity_enable_ff <= csr_pwdata[0];
            REG_PARITY_MODE:    parity_mode_ff   <= csr_pwdata[1:0];
            REG_STOP_BITS:      stop_bits_ff     <= csr_pwdata[1:0];
            REG_STEP_CH0_SPACE: tone_step_ff[0]  <= csr_pwdata[15:0];
            REG_STEP_CH0_MARK:  tone_step_ff[1]  <= csr_pwdata[15:0];
            REG_STEP_CH1_SPACE: tone_step_ff[2]  <= csr_pwdata[15:0];
            REG_STEP_CH1_MARK:  tone_step_ff[3]  <= csr_pwdata[15:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_DATA_BITS:      csr_prdata = {28'd0, data_bits_ff};
         REG_PARITY_ENABLE:  csr_prdata = {31'd0, parity_enable_ff};
         REG_PARITY_MODE:    csr_prdata = {30'd0, parity_mode_ff};
         REG_STOP_BITS:      csr_prdata = {30'd0, stop_bits_ff};
         REG_STEP_CH0_SPACE: csr_prdata = {16'd0, tone_step_ff[0]};
         REG_STEP_CH0_MARK:  csr_prdata = {16'd0, tone_step_ff[1]};
         REG_STEP_CH1_SPACE: csr_prdata = {16'd0, tone_step_ff[2]};
         REG_STEP_CH1_MARK:  csr_prdata = {16'd0, tone_step_ff[3]};
      endcase
   end

   // ---------------------------------------------------------------- handshake
   // The ROM stage may refill whenever its content leaves for the output stage.
   assign pipe_move  = !rsp_valid_ff || rsp_tready;
   assign req_tready = !pipe_valid_ff || pipe_move;
   assign req_fire   = req_tvalid && req_tready;

   // ---------------------------------------------------------------- line state
   assign req_kind    = req_tuser[1:0];
   assign req_channel = req_tuser[2];
   assign nd          = clamp_data_bits(data_bits_ff);
   assign ns          = clamp_stop_bits(stop_bits_ff);

   always_comb begin
      pushing     = (req_kind == REQ_BYTE) || (req_kind == REQ_CARRIER);
      busy_now    = bits_left_ff != 4'd0;
      // A push is turned away only when the holding word is occupied and a word is on air.
      refuse      = pushing && held_full_ff && busy_now;
      accept_push = pushing && !refuse;
      new_word    = (req_kind == REQ_BYTE)
                    ? frame_word(req_tdata, nd, parity_enable_ff, parity_mode_ff, ns)
                    : 16'hFFFF;
      // An idle line takes the held word, or the pushed word straight away when nothing
      // is held. A push onto a full buffer of an idle line moves the old word out first.
      load        = !busy_now && (held_full_ff || pushing);
      held_write  = accept_push && (held_full_ff || busy_now);
      busy        = busy_now || load;
      boundary    = samples_left_ff == 6'd0;
      take_bit    = boundary && busy;

      shift_cur   = load ? (held_full_ff ? held_word_ff : new_word) : shift_word_ff;
      bits_cur    = load ? frame_length(nd, parity_enable_ff, ns) : bits_left_ff;

      // At a bit start the tone follows the new bit; an idle period keeps the mark tone
      // of the channel last used.
      channel_sel = take_bit ? req_channel : active_channel_ff;
      bit_sel     = take_bit ? shift_cur[0] : 1'b1;
      status      = pushing ? !refuse : (busy || boundary);

      phase_top   = 8'(phase_acc_ff >> PHASE_FRAC_BITS);
      rom_index   = phase_top[5:0] ^ {6{phase_top[6]}};

      phase_acc_in      = phase_acc_ff;
      bit_step_in       = bit_step_ff;
      active_channel_in = active_channel_ff;
      samples_left_in   = samples_left_ff;
      shift_word_in     = shift_word_ff;
      held_word_in      = held_word_ff;
      held_full_in      = held_full_ff;
      bits_left_in      = bits_left_ff;

      if (req_fire) begin
         if (boundary) begin
            bit_step_in     = tone_step_ff[{channel_sel, bit_sel}];
            samples_left_in = 6'(SAMPLES_PER_BIT_PERIOD - 1);
         end else begin
            samples_left_in = samples_left_ff - 6'd1;
         end
         phase_acc_in      = phase_acc_ff + bit_step_in;
         active_channel_in = channel_sel;
         shift_word_in     = take_bit ? {1'b0, shift_cur[15:1]} : shift_cur;
         bits_left_in      = take_bit ? bits_cur - 4'd1 : bits_cur;
         if (held_write) begin
            held_word_in = new_word;
            held_full_in = 1'b1;
         end else if (load) begin
            held_full_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_acc_ff      <= 16'd0;
         bit_step_ff       <= 16'd0;
         active_channel_ff <= 1'b0;
         samples_left_ff   <= 6'd0;
         shift_word_ff     <= 16'd0;
         held_word_ff      <= 16'd0;
         held_full_ff      <= 1'b0;
         bits_left_ff      <= 4'd0;
      end else begin
         phase_acc_ff      <= phase_acc_in;
         bit_step_ff       <= bit_step_in;
         active_channel_ff <= active_channel_in;
         samples_left_ff   <= samples_left_in;
         shift_word_ff     <= shift_word_in;
         held_word_ff      <= held_word_in;
         held_full_ff      <= held_full_in;
         bits_left_ff      <= bits_left_in;
      end
   end

   // ---------------------------------------------------------------- result path
   assign pipe_valid_in = req_fire ? 1'b1 : (pipe_move ? 1'b0 : pipe_valid_ff);
   assign rsp_valid_in  = pipe_move ? pipe_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pipe_valid_ff <= pipe_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Sine quadrant ROM, synchronous read; the sign and status travel alongside.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         pipe_mag_ff    <= SINE_QUADRANT[rom_index];
         pipe_neg_ff    <= phase_top[7];
         pipe_status_ff <= status;
      end
   end

   // The negative half cycle is the one's complement of the quadrant value.
   assign mag_ext = {{(SAMPLE_WIDTH - 7){1'b0}}, pipe_mag_ff};

   always_ff @(posedge clock) begin
      if (pipe_move && pipe_valid_ff) begin
         rsp_sample_ff <= pipe_neg_ff ? ~mag_ext : mag_ext;
         rsp_status_ff <= pipe_status_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RspDataWidth'(rsp_sample_ff);
   assign rsp_tuser  = rsp_status_ff;

   // ---------------------------------------------------------------- checks
   a_sample_count: assert property (@(posedge clock) disable iff (reset)
      samples_left_ff <= 6'(SAMPLES_PER_BIT_PERIOD - 1))
      else $error("bit period counter beyond the period length");

   a_bits_count: assert property (@(posedge clock) disable iff (reset)
      bits_left_ff <= 4'(MAX_FRAME_LENGTH))
      else $error("bit counter beyond the longest frame");

   a_refused_push: assert property (@(posedge clock) disable iff (reset)
      (req_fire && pushing && held_full_ff && bits_left_ff != 4'd0) |=> !pipe_status_ff)
      else $error("push onto a full buffer of a busy line reported as taken");

   a_rom_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (pipe_valid_ff && !pipe_move) |=> (pipe_valid_ff && $stable(pipe_mag_ff)
                                         && $stable(pipe_neg_ff)))
      else $error("ROM stage content lost while the output stage stalls");

   a_output_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(pipe_valid_ff))
      else $error("result appeared without an entry in the ROM stage");

endmodule

### test/tb_fsk_uart_tone_modulator.sv
// Self-checking testbench for the FSK UART tone modulator: random and directed requests
// are checked sample by sample against a line model held in a small scoreboard class.
// Depends on fskmod_pkg and fsk_uart_tone_modulator only.
module tb_fsk_uart_tone_modulator;
   timeunit 1ns;
   timeprecision 1ps;

   import fskmod_pkg::*;

   // The block never defines request code three; it must behave as an advance.
   localparam req_kind_type REQ_UNUSED = 2'd3;

   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int PHASE_COUNT     = 5;
   localparam int PHASE_REQUESTS  = 340;
   localparam int IDLE_PERCENT    = 31;
   localparam int REPORT_CAP      = 100;

   // Framing per phase. Out-of-range data and stop bit counts are included on purpose,
   // so that the saturation of both counts is exercised.
   localparam logic [3:0]      PHASE_DATA_BITS [PHASE_COUNT] = '{4'd8, 4'd5, 4'd0, 4'd15, 4'd7};
   localparam logic            PHASE_PARITY_ON [PHASE_COUNT] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0};
   localparam parity_mode_type PHASE_PARITY    [PHASE_COUNT] =
      '{PAR_SPACE, PAR_MARK, PAR_EVEN, PAR_ODD, PAR_EVEN};
   localparam logic [1:0]      PHASE_STOP_BITS [PHASE_COUNT] = '{2'd1, 2'd2, 2'd0, 2'd3, 2'd2};

   typedef struct packed {
      logic [7:0] sample;
      logic       status;
   } tone_sample_type;

   // Line model: framing registers, the bit timer, the shift register with its one-word
   // holding buffer and the phase accumulator, plus the queue of samples still owed.
   class tone_scoreboard;
      logic [3:0]      char_bits;
      logic            parity_on;
      parity_mode_type parity_kind;
      logic [1:0]      stop_count;
      logic [15:0]     tone_step [2][2];

      logic [15:0] phase;
      logic [15:0] step_now;
      logic        tone_chan;
      logic [5:0]  samples_to_go;
      logic [15:0] shifter;
      logic [15:0] spare_word;
      logic        spare_full;
      logic [3:0]  bits_to_go;

      tone_sample_type expected_samples [$];
      int              errors;

      function new();
         char_bits   = 4'd8;
         parity_on   = 1'b0;
         parity_kind = PAR_SPACE;
         stop_count  = 2'd1;
         tone_step   = '{'{16'h0, 16'h0}, '{16'h0, 16'h0}};
         phase       = '0;
         step_now    = '0;
         tone_chan   = 1'b0;
         samples_to_go = '0;
         shifter     = '0;
         spare_word  = '0;
         spare_full  = 1'b0;
         bits_to_go  = '0;
         errors      = 0;
      endfunction

      function void set_register(reg_index_type idx, logic [15:0] value);
         case (idx)
            REG_DATA_BITS:      char_bits   = value[3:0];
            REG_PARITY_ENABLE:  parity_on   = value[0];
            REG_PARITY_MODE:    parity_kind = parity_mode_type'(value[1:0]);
            REG_STOP_BITS:      stop_count  = value[1:0];
            REG_STEP_CH0_SPACE: tone_step[0][0] = value;
            REG_STEP_CH0_MARK:  tone_step[0][1] = value;
            REG_STEP_CH1_SPACE: tone_step[1][0] = value;
            REG_STEP_CH1_MARK:  tone_step[1][1] = value;
            default: ;
         endcase
      endfunction

      function int unsigned clamped_bits();
         if (char_bits < 4'd5) return 5;
         if (char_bits > 4'd8) return 8;
         return char_bits;
      endfunction

      function int unsigned clamped_stops();
         if (stop_count == 2'd0) return 1;
         if (stop_count == 2'd3) return 2;
         return stop_count;
      endfunction

      // Start bit at bit 0, data LSB first, optional parity over all eight bits, stop bits.
      function logic [15:0] framed_word(logic [7:0] data);
         int unsigned nd;
         int unsigned w;
         logic        par;
         nd = clamped_bits();
         case (parity_kind)
            PAR_SPACE: par = 1'b0;
            PAR_MARK:  par = 1'b1;
            PAR_EVEN:  par = ^data;
            default:   par = ~(^data);
         endcase
         w = (32'd1 << clamped_stops()) - 1;
         if (parity_on) w = (w << 1) | par;
         w = (w << nd) | (data & ((32'd1 << nd) - 1));
         return 16'(w << 1);
      endfunction

      function void load_spare();
         shifter    = spare_word;
         spare_full = 1'b0;
         bits_to_go = 4'(1 + clamped_bits() + parity_on + clamped_stops());
      endfunction

      function int pending();
         return expected_samples.size();
      endfunction

      function void note_request(req_kind_type kind, logic chan, logic [7:0] data);
         logic            pushing, busy, newbit, boundary, bitval, status_bit, idle_line;
         logic [15:0]     word;
         logic [7:0]      top, mag;
         logic [5:0]      idx;
         tone_sample_type owed;
         pushing   = (kind == REQ_BYTE) || (kind == REQ_CARRIER);
         busy      = bits_to_go != 0;
         idle_line = 1'b0;
         if (pushing && spare_full && busy) begin
            // Refused: the word is dropped but the line still moves on.
            status_bit = 1'b0;
            newbit     = 1'b1;
         end else begin
            if (pushing) begin
               word = (kind == REQ_BYTE) ? framed_word(data) : 16'hFFFF;
               if (spare_full) load_spare();
               spare_word = word;
               spare_full = 1'b1;
               busy       = bits_to_go != 0;
            end
            if (spare_full && !busy) begin
               load_spare();
               busy = 1'b1;
            end
            newbit     = busy;
            status_bit = pushing || busy;
            idle_line  = !status_bit;
         end

         boundary = samples_to_go == 0;
         if (boundary) begin
            bitval        = 1'b1;
            samples_to_go = 6'(SAMPLES_PER_BIT_PERIOD);
            if (newbit) begin
               tone_chan = chan;
               bitval    = shifter[0];
            end
            step_now = tone_step[tone_chan][bitval];
         end

         top = 8'(phase >> PHASE_FRAC_BITS);
         idx = top[5:0];
         if (top[6]) idx = ~idx;
         mag = {1'b0, SINE_QUADRANT[idx]};
         if (top[7]) mag = ~mag;

         phase = phase + step_now;
         if (samples_to_go != 0) samples_to_go = samples_to_go - 6'd1;
         if (boundary && newbit) begin
            shifter    = shifter >> 1;
            bits_to_go = bits_to_go - 4'd1;
         end
         if (idle_line) status_bit = boundary;

         owed.sample = mag;
         owed.status = status_bit;
         expected_samples.push_back(owed);
      endfunction

      task report(string msg);
         if (errors < REPORT_CAP) $display("mismatch: %s", msg);
         errors++;
      endtask

      task check_result(logic [7:0] sample, logic status);
         tone_sample_type want;
         if (expected_samples.size() == 0) begin
            report($sformatf("sample %0d status %0b with no request outstanding",
                             $signed(sample), status));
            return;
         end
         want = expected_samples.pop_front();
         if (sample !== want.sample)
            report($sformatf("sample %0d, expected %0d", $signed(sample), $signed(want.sample)));
         if (status !== want.status)
            report($sformatf("status %0b, expected %0b", status, want.status));
      endtask
   endclass

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = '0;   // [7:0] data_byte
   logic [2:0]  req_tuser   = '0;   // [1:0] req_type, [2] channel
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [7:0]  rsp_tdata;          // [7:0] sample
   logic        rsp_tuser;          // [0] status
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   tone_scoreboard board = new();

   // When set, neither side idles: requests and results flow at full rate.
   logic steady = 1'b0;
   int   stall_cycles = 0;

   fsk_uart_tone_modulator dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   // The receiver stalls at random, except during the steady stretch.
   always @(posedge clock) begin
      if (steady) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Both channels are sampled on the same edge. A result can never belong to a request
   // taken on that edge, so checking before noting keeps the queue order correct. The
   // watchdog counts edges on which neither channel moves.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            board.check_result(rsp_tdata, rsp_tuser);
         end
         if (req_tvalid && req_tready) begin
            board.note_request(req_kind_type'(req_tuser[1:0]), req_tuser[2], req_tdata);
         end
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   // Offers one request, with random idle cycles in front of it, and returns on the edge
   // at which it is taken.
   task automatic send_request(req_kind_type kind, logic chan, logic [7:0] data);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= {chan, kind};
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Setup and access cycle of one register write. The select is left high so that
   // writes can follow back to back; the caller drops it after the last one.
   task automatic write_register(reg_index_type idx, logic [15:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_WIDTH'({idx, 2'b00});
      csr_pwdata  <= {16'h0000, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      board.set_register(idx, value);
   endtask

   task automatic wait_for_results();
      do @(posedge clock); while (board.pending() != 0);
   endtask

   initial begin
      req_kind_type kind;
      logic [15:0]  step;
      int           roll;
      int           quiet_left;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Under the reset framing, with every tone step still zero. The first request lands
      // on a bit boundary of an empty line, so the loaded word must begin with its own
      // start bit; the carrier then fills the holding buffer and the next byte is refused.
      send_request(REQ_BYTE,    1'b1, 8'hFF);
      send_request(REQ_CARRIER, 1'b0, 8'h00);
      send_request(REQ_BYTE,    1'b0, 8'h00);
      send_request(REQ_UNUSED,  1'b1, 8'hA5);
      send_request(REQ_ADVANCE, 1'b0, 8'h5A);

      quiet_left = 0;
      for (int p = 0; p < PHASE_COUNT; p++) begin
         // Framing only changes once every sample owed has come back. This is also the
         // point at which the sender holds off completely.
         req_tvalid <= 1'b0;
         wait_for_results();
         write_register(REG_DATA_BITS,     {12'h000, PHASE_DATA_BITS[p]});
         write_register(REG_PARITY_ENABLE, {15'h0000, PHASE_PARITY_ON[p]});
         write_register(REG_PARITY_MODE,   {14'h0000, PHASE_PARITY[p]});
         write_register(REG_STOP_BITS,     {14'h0000, PHASE_STOP_BITS[p]});
         // The second phase takes the step extremes, the others random tones.
         for (int t = 0; t < 4; t++) begin
            if (p == 1) begin
               step = (t == 1 || t == 2) ? 16'hFFFF : 16'h0000;
            end else begin
               step = 16'($urandom_range(65535));
            end
            write_register(reg_index_type'(REG_STEP_CH0_SPACE + t), step);
         end
         csr_psel    <= 1'b0;
         csr_penable <= 1'b0;

         // The third phase runs without idling on either side.
         steady = (p == 2);

         if (p == 0) begin
            send_request(REQ_BYTE,    1'b0, 8'h00);
            send_request(REQ_BYTE,    1'b1, 8'hFF);
            send_request(REQ_CARRIER, 1'b1, 8'hFF);
            send_request(REQ_UNUSED,  1'b0, 8'h00);
            send_request(REQ_ADVANCE, 1'b1, 8'hAA);
            send_request(REQ_BYTE,    1'b0, 8'h55);
            send_request(REQ_CARRIER, 1'b0, 8'h0F);
            send_request(REQ_ADVANCE, 1'b0, 8'hF0);
         end

         // Mostly advances with pushes mixed in, so that words are framed back to back
         // and many pushes find the buffer full. Now and then a quiet stretch of advances
         // lets the line run dry, so that idle bit starts are seen and the next push
         // meets an empty line at a random point of the bit period.
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            if (quiet_left != 0) begin
               quiet_left--;
               kind = REQ_ADVANCE;
            end else begin
               roll = $urandom_range(999);
               if (roll < 4) begin
                  quiet_left = $urandom_range(400, 60);
                  kind = REQ_ADVANCE;
               end else if (roll < 90) begin
                  kind = REQ_BYTE;
               end else if (roll < 120) begin
                  kind = REQ_CARRIER;
               end else if (roll < 150) begin
                  kind = REQ_UNUSED;
               end else begin
                  kind = REQ_ADVANCE;
               end
            end
            send_request(kind, 1'($urandom_range(1)), 8'($urandom_range(255)));
         end
      end

      req_tvalid <= 1'b0;
      wait_for_results();
      // A few more edges so that any surplus result would still be caught.
      repeat (8) @(posedge clock);
      if (board.errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

### filelist.f
hw/rtl/fskmod_pkg.sv
hw/rtl/fsk_uart_tone_modulator.sv
test/tb_fsk_uart_tone_modulator.sv
